### hdl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   // request opcodes as they arrive on the bus
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;
   localparam logic [2:0] OP_WAIT  = 3'd5;

   // register indexes on the csr port
   localparam logic [2:0] CSR_START_HOLD = 3'd0;
   localparam logic [2:0] CSR_STOP_SETUP = 3'd1;
   localparam logic [2:0] CSR_BIT_HALF   = 3'd2;
   localparam logic [2:0] CSR_ACK_HIGH   = 3'd3;
   localparam logic [2:0] CSR_ACK_TMO    = 3'd4;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // decoded command class
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_READ,
      CMD_WAIT_ACK
   } cmd_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_ST_SETUP = 4'd1,
      PH_ST_HOLD  = 4'd2,
      PH_SP_LOW   = 4'd3,
      PH_SP_SETUP = 4'd4,
      PH_SP_HOLD  = 4'd5,
      PH_WR_LOW   = 4'd6,
      PH_WR_HIGH  = 4'd7,
      PH_WA_SETUP = 4'd8,
      PH_WA_POLL  = 4'd9,
      PH_RD_LOW   = 4'd10,
      PH_RD_HIGH  = 4'd11,
      PH_RA_LOW   = 4'd12,
      PH_RA_HIGH  = 4'd13
   } phase_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } item_type;

   // head of the request queue as seen by the sequencer
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_enable;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_missing;
   } result_type;

endpackage

### hdl/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Takes requests, decodes the opcode and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module i2cm_front
   import i2cm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output head_type              head,
   input  logic                  pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   item_dec;
   logic       push;

   // opcodes 6 and 7 fall through as plain ticks
   always_comb begin
      unique case (req_tdata[2:0])
         OP_START: item_dec.cmd = CMD_START;
         OP_STOP:  item_dec.cmd = CMD_STOP;
         OP_WRITE: item_dec.cmd = CMD_WRITE;
         OP_READ:  item_dec.cmd = CMD_READ;
         OP_WAIT:  item_dec.cmd = CMD_WAIT_ACK;
         default:  item_dec.cmd = CMD_NONE;
      endcase
      item_dec.tx_byte  = req_tdata[10:3];
      item_dec.send_ack = req_tdata[11];
      item_dec.sda_in   = req_tdata[12];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_dec;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];

endmodule

### hdl/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus sequencer: runs one tick per queued request, holds csr and result.
// ----------------------------------------------------------------------------
module i2cm_seq
   import i2cm_pkg::*;
#(
   parameter int unsigned DELAY_COUNT_BITS = 8
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata,
   input  head_type   head,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output result_type result
);

   localparam int SPAN_W = (DELAY_COUNT_BITS > 8) ? DELAY_COUNT_BITS : 8;
   localparam logic [SPAN_W-1:0] CNT_MAX = SPAN_W'({DELAY_COUNT_BITS{1'b1}});

   logic [7:0] start_hold_ff, stop_setup_ff, bit_half_ff, ack_high_ff, ack_tmo_ff;

   phase_type                   phase_ff, phase_in;
   logic [DELAY_COUNT_BITS-1:0] tick_ff, tick_in, tick_inc;
   logic [3:0]                  bit_cnt_ff, bit_cnt_in, bit_cnt_inc;
   logic [7:0]                  shift_ff, shift_in, shift_wr, shift_rd;
   logic [7:0]                  tmo_cnt_ff, tmo_cnt_in;
   logic                        scl_ff, scl_in;
   logic                        sda_ff, sda_in;
   logic                        oe_ff, oe_in;
   logic [7:0]                  rx_ff, rx_in;
   logic                        ack_miss_ff, ack_miss_in;
   logic                        ack_choice_ff, ack_choice_in;
   logic                        done_ff, done_in;
   logic                        valid_ff;

   logic [7:0]        len_sel;
   logic [SPAN_W-1:0] span_len;
   logic              elapsed;
   logic              tmo_hit;
   item_type          it;

   function automatic logic [SPAN_W-1:0] span_of(input logic [7:0] r);
      logic [SPAN_W-1:0] v;
      v = SPAN_W'(r);
      if (v == '0) v = SPAN_W'(1);
      if (v > CNT_MAX) v = CNT_MAX;
      return v;
   endfunction

   // a tick is taken when the result slot is free or being drained
   assign pop = head.valid && (!valid_ff || rsp_tready);
   assign it  = head.item;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_hold_ff <= 8'd6;
         stop_setup_ff <= 8'd6;
         bit_half_ff   <= 8'd2;
         ack_high_ff   <= 8'd5;
         ack_tmo_ff    <= 8'd250;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_HOLD: start_hold_ff <= csr_wdata;
            CSR_STOP_SETUP: stop_setup_ff <= csr_wdata;
            CSR_BIT_HALF:   bit_half_ff   <= csr_wdata;
            CSR_ACK_HIGH:   ack_high_ff   <= csr_wdata;
            CSR_ACK_TMO:    ack_tmo_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // phase length select and the single shared tick counter compare
   always_comb begin
      unique case (phase_ff) inside
         PH_ST_SETUP, PH_ST_HOLD:  len_sel = start_hold_ff;
         PH_SP_LOW:                len_sel = 8'd1;
         PH_SP_SETUP, PH_SP_HOLD:  len_sel = stop_setup_ff;
         PH_RA_HIGH:               len_sel = ack_high_ff;
         default:                  len_sel = bit_half_ff;
      endcase
   end

   assign span_len    = span_of(len_sel);
   assign tick_inc    = (tick_ff != '1) ? tick_ff + 1'b1 : tick_ff;
   assign elapsed     = (SPAN_W'(tick_inc) >= span_len);
   assign tmo_hit     = (tmo_cnt_ff >= ack_tmo_ff);
   assign bit_cnt_inc = bit_cnt_ff + 4'd1;
   assign shift_wr    = {shift_ff[6:0], 1'b0};
   assign shift_rd    = {shift_ff[6:0], it.sda_in};

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            case (it.cmd)
               CMD_START:    phase_in = PH_ST_SETUP;
               CMD_STOP:     phase_in = PH_SP_LOW;
               CMD_WRITE:    phase_in = PH_WR_LOW;
               CMD_READ:     phase_in = PH_RD_LOW;
               CMD_WAIT_ACK: phase_in = PH_WA_SETUP;
               default:      phase_in = PH_IDLE;
            endcase
         end
         PH_ST_SETUP: if (elapsed) phase_in = PH_ST_HOLD;
         PH_ST_HOLD:  if (elapsed) phase_in = PH_IDLE;
         PH_SP_LOW:   if (elapsed) phase_in = PH_SP_SETUP;
         PH_SP_SETUP: if (elapsed) phase_in = PH_SP_HOLD;
         PH_SP_HOLD:  if (elapsed) phase_in = PH_IDLE;
         PH_WR_LOW:   if (elapsed) phase_in = PH_WR_HIGH;
         PH_WR_HIGH: begin
            if (elapsed) phase_in = (bit_cnt_inc >= 4'd8) ? PH_IDLE : PH_WR_LOW;
         end
         PH_WA_SETUP: if (elapsed) phase_in = PH_WA_POLL;
         PH_WA_POLL: begin
            if (!it.sda_in) begin
               phase_in = PH_IDLE;
            end else if (tmo_hit) begin
               phase_in = PH_SP_LOW;
            end
         end
         PH_RD_LOW:   if (elapsed) phase_in = PH_RD_HIGH;
         PH_RD_HIGH: begin
            if (elapsed) phase_in = (bit_cnt_inc >= 4'd8) ? PH_RA_LOW : PH_RD_LOW;
         end
         PH_RA_LOW:   if (elapsed) phase_in = PH_RA_HIGH;
         PH_RA_HIGH:  if (elapsed) phase_in = PH_IDLE;
         default:     phase_in = PH_IDLE;
      endcase
   end

   // pins, counters and data registers
   always_comb begin
      tick_in       = tick_inc;
      bit_cnt_in    = bit_cnt_ff;
      shift_in      = shift_ff;
      tmo_cnt_in    = tmo_cnt_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      oe_in         = oe_ff;
      rx_in         = rx_ff;
      ack_miss_in   = ack_miss_ff;
      ack_choice_in = ack_choice_ff;
      done_in       = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            tick_in = '0;
            case (it.cmd)
               CMD_START: begin
                  scl_in = 1'b1; sda_in = 1'b1; oe_in = 1'b1;
               end
               CMD_STOP: begin
                  scl_in = 1'b0; sda_in = 1'b0; oe_in = 1'b1;
               end
               CMD_WRITE: begin
                  shift_in   = it.tx_byte;
                  bit_cnt_in = 4'd0;
                  scl_in = 1'b0; sda_in = it.tx_byte[7]; oe_in = 1'b1;
               end
               CMD_READ: begin
                  shift_in      = 8'd0;
                  bit_cnt_in    = 4'd0;
                  ack_choice_in = it.send_ack;
                  scl_in = 1'b0; oe_in = 1'b0;
               end
               CMD_WAIT_ACK: begin
                  tmo_cnt_in  = 8'd0;
                  ack_miss_in = 1'b0;
                  scl_in = 1'b0; sda_in = 1'b1; oe_in = 1'b0;
               end
               default: tick_in = tick_ff;
            endcase
         end
         PH_ST_SETUP: if (elapsed) begin
            tick_in = '0; scl_in = 1'b1; sda_in = 1'b0; oe_in = 1'b1;
         end
         PH_ST_HOLD: if (elapsed) begin
            tick_in = '0; scl_in = 1'b0; sda_in = 1'b0; oe_in = 1'b1;
            done_in = 1'b1;
         end
         PH_SP_LOW: if (elapsed) begin
            tick_in = '0; scl_in = 1'b1; sda_in = 1'b0; oe_in = 1'b1;
         end
         PH_SP_SETUP: if (elapsed) begin
            tick_in = '0; scl_in = 1'b1; sda_in = 1'b1; oe_in = 1'b1;
         end
         PH_SP_HOLD: if (elapsed) begin
            tick_in = '0; scl_in = 1'b1; sda_in = 1'b1; oe_in = 1'b1;
            done_in = 1'b1;
         end
         PH_WR_LOW: if (elapsed) begin
            tick_in = '0; scl_in = 1'b1; oe_in = 1'b1;
         end
         PH_WR_HIGH: if (elapsed) begin
            tick_in    = '0;
            bit_cnt_in = bit_cnt_inc;
            shift_in   = shift_wr;
            scl_in     = 1'b0;
            oe_in      = 1'b1;
            if (bit_cnt_inc >= 4'd8) begin
               done_in = 1'b1;
            end else begin
               sda_in = shift_wr[7];
            end
         end
         PH_WA_SETUP: if (elapsed) begin
            tick_in = '0; scl_in = 1'b1; sda_in = 1'b1; oe_in = 1'b0;
         end
         PH_WA_POLL: begin
            tick_in = tick_ff;
            if (!it.sda_in) begin
               tick_in = '0; scl_in = 1'b0; sda_in = 1'b1; oe_in = 1'b0;
               done_in = 1'b1;
            end else if (tmo_hit) begin
               // no ack: flag it and fall into a stop sequence
               ack_miss_in = 1'b1;
               tick_in = '0; scl_in = 1'b0; sda_in = 1'b0; oe_in = 1'b1;
            end else begin
               tmo_cnt_in = tmo_cnt_ff + 8'd1;
            end
         end
         PH_RD_LOW: if (elapsed) begin
            tick_in = '0; scl_in = 1'b1; oe_in = 1'b0;
         end
         PH_RD_HIGH: if (elapsed) begin
            tick_in    = '0;
            shift_in   = shift_rd;
            bit_cnt_in = bit_cnt_inc;
            scl_in     = 1'b0;
            if (bit_cnt_inc >= 4'd8) begin
               rx_in  = shift_rd;
               sda_in = ~ack_choice_ff;
               oe_in  = 1'b1;
            end else begin
               oe_in = 1'b0;
            end
         end
         PH_RA_LOW: if (elapsed) begin
            tick_in = '0; scl_in = 1'b1; oe_in = 1'b1;
         end
         PH_RA_HIGH: if (elapsed) begin
            tick_in = '0; scl_in = 1'b0; oe_in = 1'b1;
            done_in = 1'b1;
         end
         default: tick_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_ff       <= '0;
         bit_cnt_ff    <= 4'd0;
         shift_ff      <= 8'd0;
         tmo_cnt_ff    <= 8'd0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         oe_ff         <= 1'b1;
         rx_ff         <= 8'd0;
         ack_miss_ff   <= 1'b0;
         ack_choice_ff <= 1'b0;
         done_ff       <= 1'b0;
      end else if (pop) begin
         phase_ff      <= phase_in;
         tick_ff       <= tick_in;
         bit_cnt_ff    <= bit_cnt_in;
         shift_ff      <= shift_in;
         tmo_cnt_ff    <= tmo_cnt_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         oe_ff         <= oe_in;
         rx_ff         <= rx_in;
         ack_miss_ff   <= ack_miss_in;
         ack_choice_ff <= ack_choice_in;
         done_ff       <= done_in;
      end
   end

   // the state registers double as the result slot: they move only on pop
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid         = valid_ff;
   assign result.scl_level   = scl_ff;
   assign result.sda_level   = sda_ff;
   assign result.sda_enable  = oe_ff;
   assign result.busy_res    = (phase_ff != PH_IDLE);
   assign result.done_res    = done_ff;
   assign result.rx_byte     = rx_ff;
   assign result.ack_missing = ack_miss_ff;

endmodule

### hdl/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Bit-banged I2C master: one request is one bus timing tick, one response
// per request carries the pin levels and command status after that tick.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    tdata: opcode, tx_byte, send_ack, sda_in
//  rsp      out  rsp_tvalid/tready    tdata: pins, busy, done, rx_byte, ack_missing
//  csr      in   csr_we               csr_index, csr_wdata (no read-back)
//
//  One request per clock sustained while rsp is not stalled; a request is
//  queued at the accepting edge, then stepped by the sequencer into the
//  result slot, which raises rsp valid. The sequencer's phase/tick loop is
//  the step that sets the rate.
//  Reset (synchronous, high) leaves the bus idle-high, SDA driven, default
//  timings loaded and both queue and result slot empty.
//  A stalled rsp holds the sequencer; the two-entry queue keeps req_tready
//  high until it fills, so the front keeps taking requests meanwhile.
//  Commands that arrive while a command is running are dropped (busy).
// ----------------------------------------------------------------------------
module i2c_master_byte_engine
   import i2cm_pkg::*;
#(
   parameter int unsigned DELAY_COUNT_BITS = 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   // requests
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // opcode[2:0], tx_byte[10:3],
                                             // send_ack[11], sda_in[12], zero
   // responses
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // scl[0], sda[1], sda_en[2],
                                             // busy[3], done[4], rx_byte[12:5],
                                             // ack_missing[13], zero
   // timing registers
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [7:0]            csr_wdata
);

   head_type   head;
   logic       pop;
   result_type result;

   // front: decode and queue
   i2cm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .head       (head),
      .pop        (pop)
   );

   // back: bus sequencer with result slot
   i2cm_seq #(
      .DELAY_COUNT_BITS (DELAY_COUNT_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .result     (result)
   );

   assign rsp_tdata = {2'b00,
                       result.ack_missing,
                       result.rx_byte,
                       result.done_res,
                       result.busy_res,
                       result.sda_enable,
                       result.sda_level,
                       result.scl_level};

endmodule

### verif/i2c_master_byte_engine_check.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_check
// Watches the request, response and csr ports of the I2C byte engine, runs
// a cycle-true copy of the bus sequencer on every accepted request and
// compares each accepted response field by field with the oldest predicted
// pin state.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_check
   import i2cm_pkg::*;
#(
   parameter int unsigned DELAY_COUNT_BITS = 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [7:0]            csr_wdata,
   output int                    fail_count,
   output int                    pending,
   output logic                  engine_idle,
   output int                    rsp_checked,
   output int                    done_seen,
   output int                    tmo_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CNT_MAX = (1 << DELAY_COUNT_BITS) - 1;

   // timing registers as last written
   logic [7:0] cfg_start_hold, cfg_stop_setup, cfg_bit_half, cfg_ack_high, cfg_ack_tmo;

   // sequencer copy
   phase_type  ph;
   int         tick_cnt;
   logic [3:0] bit_cnt;
   logic [7:0] shreg, tmo_cnt, rx_q;
   logic       scl_q, sda_q, oe_q, ack_miss_q, ack_sel;

   result_type pin_states_due[$];
   int         mismatches, rsp_n, done_n, tmo_n;

   function automatic int span_of(input logic [7:0] len);
      int v;
      v = len;
      if (v == 0) v = 1;
      if (v > CNT_MAX) v = CNT_MAX;
      return v;
   endfunction

   function automatic bit expired(input logic [7:0] len);
      if (tick_cnt < CNT_MAX) tick_cnt++;
      return tick_cnt >= span_of(len);
   endfunction

   function automatic void move_to(input phase_type p, input logic scl, sda, oe);
      ph       = p;
      scl_q    = scl;
      sda_q    = sda;
      oe_q     = oe;
      tick_cnt = 0;
   endfunction

   function automatic void clear_bus();
      cfg_start_hold = 8'd6;
      cfg_stop_setup = 8'd6;
      cfg_bit_half   = 8'd2;
      cfg_ack_high   = 8'd5;
      cfg_ack_tmo    = 8'd250;
      ph             = PH_IDLE;
      tick_cnt       = 0;
      bit_cnt        = '0;
      shreg          = '0;
      tmo_cnt        = '0;
      rx_q           = '0;
      scl_q          = 1'b1;
      sda_q          = 1'b1;
      oe_q           = 1'b1;
      ack_miss_q     = 1'b0;
      ack_sel        = 1'b0;
   endfunction

   // one timing tick of the sequencer
   task automatic bus_tick(input logic [REQ_DATA_W-1:0] d, output result_type r);
      logic [2:0] op;
      logic [7:0] tx;
      logic       sack, sin, fin;
      op   = d[2:0];
      tx   = d[10:3];
      sack = d[11];
      sin  = d[12];
      fin  = 1'b0;
      case (ph)
         PH_IDLE: begin
            case (op)
               OP_START: move_to(PH_ST_SETUP, 1'b1, 1'b1, 1'b1);
               OP_STOP:  move_to(PH_SP_LOW, 1'b0, 1'b0, 1'b1);
               OP_WRITE: begin
                  shreg   = tx;
                  bit_cnt = '0;
                  move_to(PH_WR_LOW, 1'b0, shreg[7], 1'b1);
               end
               OP_READ: begin
                  shreg   = '0;
                  bit_cnt = '0;
                  ack_sel = sack;
                  move_to(PH_RD_LOW, 1'b0, sda_q, 1'b0);
               end
               OP_WAIT: begin
                  tmo_cnt    = '0;
                  ack_miss_q = 1'b0;
                  move_to(PH_WA_SETUP, 1'b0, 1'b1, 1'b0);
               end
               default: ;
            endcase
         end
         PH_ST_SETUP: if (expired(cfg_start_hold)) move_to(PH_ST_HOLD, 1'b1, 1'b0, 1'b1);
         PH_ST_HOLD: if (expired(cfg_start_hold)) begin
            move_to(PH_IDLE, 1'b0, 1'b0, 1'b1);
            fin = 1'b1;
         end
         PH_SP_LOW: if (expired(8'd1)) move_to(PH_SP_SETUP, 1'b1, 1'b0, 1'b1);
         PH_SP_SETUP: if (expired(cfg_stop_setup)) move_to(PH_SP_HOLD, 1'b1, 1'b1, 1'b1);
         PH_SP_HOLD: if (expired(cfg_stop_setup)) begin
            move_to(PH_IDLE, 1'b1, 1'b1, 1'b1);
            fin = 1'b1;
         end
         PH_WR_LOW: if (expired(cfg_bit_half)) move_to(PH_WR_HIGH, 1'b1, sda_q, 1'b1);
         PH_WR_HIGH: if (expired(cfg_bit_half)) begin
            bit_cnt = bit_cnt + 4'd1;
            shreg   = {shreg[6:0], 1'b0};
            if (bit_cnt >= 4'd8) begin
               move_to(PH_IDLE, 1'b0, sda_q, 1'b1);
               fin = 1'b1;
            end else begin
               move_to(PH_WR_LOW, 1'b0, shreg[7], 1'b1);
            end
         end
         PH_WA_SETUP: if (expired(cfg_bit_half)) move_to(PH_WA_POLL, 1'b1, 1'b1, 1'b0);
         PH_WA_POLL: begin
            if (!sin) begin
               move_to(PH_IDLE, 1'b0, 1'b1, 1'b0);
               fin = 1'b1;
            end else if (tmo_cnt >= cfg_ack_tmo) begin
               // no ack in time: flag it and run a stop
               ack_miss_q = 1'b1;
               tmo_n++;
               move_to(PH_SP_LOW, 1'b0, 1'b0, 1'b1);
            end else begin
               tmo_cnt = tmo_cnt + 8'd1;
            end
         end
         PH_RD_LOW: if (expired(cfg_bit_half)) move_to(PH_RD_HIGH, 1'b1, sda_q, 1'b0);
         PH_RD_HIGH: if (expired(cfg_bit_half)) begin
            shreg   = {shreg[6:0], sin};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 4'd8) begin
               rx_q = shreg;
               move_to(PH_RA_LOW, 1'b0, !ack_sel, 1'b1);
            end else begin
               move_to(PH_RD_LOW, 1'b0, sda_q, 1'b0);
            end
         end
         PH_RA_LOW: if (expired(cfg_bit_half)) move_to(PH_RA_HIGH, 1'b1, sda_q, 1'b1);
         PH_RA_HIGH: if (expired(cfg_ack_high)) begin
            move_to(PH_IDLE, 1'b0, sda_q, 1'b1);
            fin = 1'b1;
         end
         default: move_to(PH_IDLE, scl_q, sda_q, oe_q);
      endcase
      if (fin) done_n++;
      r.scl_level   = scl_q;
      r.sda_level   = sda_q;
      r.sda_enable  = oe_q;
      r.busy_res    = (ph != PH_IDLE);
      r.done_res    = fin;
      r.rx_byte     = rx_q;
      r.ack_missing = ack_miss_q;
   endtask

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         if (mismatches < 10)
            $display("mismatch in %s of response %0d: expected %0h, got %0h",
                     name, rsp_n, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      result_type want, got;
      if (reset) begin
         clear_bus();
         pin_states_due.delete();
         mismatches = 0;
         rsp_n      = 0;
         done_n     = 0;
         tmo_n      = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_START_HOLD: cfg_start_hold = csr_wdata;
               CSR_STOP_SETUP: cfg_stop_setup = csr_wdata;
               CSR_BIT_HALF:   cfg_bit_half   = csr_wdata;
               CSR_ACK_HIGH:   cfg_ack_high   = csr_wdata;
               CSR_ACK_TMO:    cfg_ack_tmo    = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            bus_tick(req_tdata, want);
            pin_states_due.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.scl_level   = rsp_tdata[0];
            got.sda_level   = rsp_tdata[1];
            got.sda_enable  = rsp_tdata[2];
            got.busy_res    = rsp_tdata[3];
            got.done_res    = rsp_tdata[4];
            got.rx_byte     = rsp_tdata[12:5];
            got.ack_missing = rsp_tdata[13];
            rsp_n++;
            if (pin_states_due.size() == 0) begin
               if (mismatches < 10)
                  $display("response %0d arrived with no request outstanding: %0h",
                           rsp_n, rsp_tdata);
               mismatches++;
            end else begin
               want = pin_states_due.pop_front();
               check_field("scl_level", want.scl_level, got.scl_level);
               check_field("sda_level", want.sda_level, got.sda_level);
               check_field("sda_enable", want.sda_enable, got.sda_enable);
               check_field("busy_res", want.busy_res, got.busy_res);
               check_field("done_res", want.done_res, got.done_res);
               check_field("rx_byte", want.rx_byte, got.rx_byte);
               check_field("ack_missing", want.ack_missing, got.ack_missing);
            end
         end
      end
      fail_count  <= mismatches;
      pending     <= pin_states_due.size();
      engine_idle <= (ph == PH_IDLE);
      rsp_checked <= rsp_n;
      done_seen   <= done_n;
      tmo_seen    <= tmo_n;
   end

endmodule

### verif/i2c_master_byte_engine_test.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_test
// Stimulus and verdict for the I2C byte engine: directed commands at reset,
// minimum and zero timings, then random I2C transactions (start, address
// write, ack wait, reads, writes, stop) mixed with noise over several timing
// settings, with random stalls on both channels. The checker beside the
// engine predicts every response.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_test;
   timeunit 1ns;
   timeprecision 1ps;
   import i2cm_pkg::*;

   // opcodes outside the command set, decoded as plain ticks
   localparam logic [2:0] OP_RSVD6 = 3'd6;
   localparam logic [2:0] OP_RSVD7 = 3'd7;

   // how the slave drives SDA while a command runs
   localparam int SDA_LOW  = 0;
   localparam int SDA_HIGH = 1;
   localparam int SDA_RAND = 2;

   // Slowest legal run is well under 10k requests, each slowed by a random
   // sender gap, a random response stall and the pipeline; the watchdog
   // LIMIT leaves several times that.
   localparam int LIMIT        = 1000000;
   localparam int TICK_BURST   = 16;  // ticks sent between idle checks
   localparam int HOLD_CYCLES  = 80;  // long response back-pressure
   localparam int DRAIN_CYCLES = 8;   // drain time past the response latency

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // opcode, tx_byte, send_ack, sda_in, zero
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // scl, sda, sda_en, busy, done, rx_byte,
                                            // ack_missing, zero
   logic                  csr_we     = 1'b0;
   logic [2:0]            csr_index  = '0;
   logic [7:0]            csr_wdata  = '0;

   int   fail_count, pending, rsp_checked, done_seen, tmo_seen;
   logic engine_idle;

   bit         quiet        = 1'b0;   // no idling on either side
   bit         hold_go      = 1'b0;   // ask the receiver for one long stall
   bit         hold_done    = 1'b0;
   int         cycle_count  = 0;
   int         settings_run = 0;
   logic       sda_line     = 1'b1;   // slave SDA level, held in runs
   int         sda_high_run = 8;      // mean length of a high SDA run
   logic [2:0] last_cmd     = OP_STOP;

   always begin
      #5;
      clock = 1'b1;
      #5;
      clock = 1'b0;
   end

   i2c_master_byte_engine #(.DELAY_COUNT_BITS(8)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   i2c_master_byte_engine_check #(.DELAY_COUNT_BITS(8)) u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .pending     (pending),
      .engine_idle (engine_idle),
      .rsp_checked (rsp_checked),
      .done_seen   (done_seen),
      .tmo_seen    (tmo_seen)
   );

   function automatic logic [REQ_DATA_W-1:0] pack_req(input logic [2:0] op,
                                                      input logic [7:0] tx,
                                                      input logic ack, sda);
      logic [REQ_DATA_W-1:0] d;
      d       = '0;
      d[2:0]  = op;
      d[10:3] = tx;
      d[11]   = ack;
      d[12]   = sda;
      return d;
   endfunction

   // SDA from the slave: fixed, or random in runs so long high stretches
   // can reach the ack timeout
   function automatic logic pick_sda(input int mode);
      case (mode)
         SDA_LOW:  return 1'b0;
         SDA_HIGH: return 1'b1;
         default: begin
            if (sda_line) begin
               if ($urandom_range(1, sda_high_run) == 1) sda_line = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
               sda_line = 1'b1;
            end
            return sda_line;
         end
      endcase
   endfunction

   // Offer one request and hold it until accepted; an optional idle burst
   // comes first so valid never drops and rises in the same step.
   task automatic put_request(input logic [2:0] op, input logic [7:0] tx,
                              input logic ack, sda);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tdata  <= pack_req(op, tx, ack, sda);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop sending until every predicted response is back, then let the
   // pipeline empty.
   task automatic idle_sender();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Tick the engine until the running command has finished.
   task automatic settle(input int mode);
      idle_sender();
      while (!engine_idle) begin
         repeat (TICK_BURST) put_request(OP_TICK, 8'($urandom), 1'($urandom), pick_sda(mode));
         idle_sender();
      end
   endtask

   task automatic run_command(input logic [2:0] op, input logic [7:0] tx,
                              input logic ack, input int mode);
      put_request(op, tx, ack, pick_sda(mode));
      settle(mode);
   endtask

   // Timing registers only change with the engine idle and nothing in flight.
   task automatic load_timing(input logic [7:0] sh, sp, bh, ah, at);
      logic [7:0] vals[5];
      logic [2:0] regs[5];
      vals = '{sh, sp, bh, ah, at};
      regs = '{CSR_START_HOLD, CSR_STOP_SETUP, CSR_BIT_HALF, CSR_ACK_HIGH, CSR_ACK_TMO};
      settle(SDA_RAND);
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      settings_run++;
   endtask

   // Mostly ticks; when the engine looks idle, half the time a command,
   // usually the next of a well-formed transaction, else a random opcode.
   // Random opcodes also land while busy, where they must be dropped.
   task automatic random_traffic(input int n, input int high_run);
      logic [2:0] op;
      sda_high_run = high_run;
      repeat (n) begin
         if (engine_idle && $urandom_range(0, 1) == 0) begin
            if ($urandom_range(0, 4) != 0) begin
               case (last_cmd) inside
                  OP_START: op = OP_WRITE;          // address byte
                  OP_WRITE: op = OP_WAIT;
                  OP_WAIT, OP_READ: begin
                     case ($urandom_range(0, 3))
                        0: op = OP_STOP;
                        1: op = OP_READ;
                        default: op = OP_WRITE;
                     endcase
                  end
                  default: op = OP_START;
               endcase
               last_cmd = op;
            end else begin
               op = 3'($urandom_range(0, 7));
            end
         end else if ($urandom_range(0, 15) == 0) begin
            op = 3'($urandom_range(0, 7));
         end else begin
            op = OP_TICK;
         end
         put_request(op, 8'($urandom), 1'($urandom), pick_sda(SDA_RAND));
      end
   endtask

   // response side: random stalls, plus one long hold on request
   initial begin : rsp_side
      @(posedge clock);
      forever begin
         if (hold_go && !hold_done) begin
            rsp_tready <= 1'b0;
            hold_done   = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin : watchdog
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_count, pending);
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset timings: start, both byte extremes, slave ack, stop
      run_command(OP_START, 8'h00, 1'b0, SDA_RAND);
      run_command(OP_WRITE, 8'h00, 1'b0, SDA_RAND);
      run_command(OP_WRITE, 8'hFF, 1'b1, SDA_RAND);
      run_command(OP_WAIT, 8'h00, 1'b0, SDA_LOW);
      run_command(OP_STOP, 8'h00, 1'b0, SDA_RAND);

      // shortest timings
      load_timing(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
      run_command(OP_START, 8'h00, 1'b0, SDA_RAND);
      run_command(OP_READ, 8'h00, 1'b1, SDA_HIGH);   // all ones, ACK
      run_command(OP_READ, 8'h00, 1'b0, SDA_LOW);    // all zeros, NACK
      run_command(OP_WAIT, 8'h00, 1'b0, SDA_LOW);    // slave acks at once
      run_command(OP_WAIT, 8'h00, 1'b0, SDA_HIGH);   // one extra high sample
      run_command(OP_RSVD6, 8'hFF, 1'b1, SDA_RAND);
      run_command(OP_RSVD7, 8'hFF, 1'b1, SDA_RAND);
      // a command right behind another is dropped while busy
      put_request(OP_START, 8'h00, 1'b0, 1'b1);
      put_request(OP_WRITE, 8'h5A, 1'b0, 1'b1);
      settle(SDA_RAND);
      run_command(OP_WRITE, 8'hA5, 1'b0, SDA_RAND);
      run_command(OP_STOP, 8'h00, 1'b0, SDA_RAND);

      // zero lengths act as one tick; zero timeout gives up on first high
      load_timing(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      run_command(OP_START, 8'h00, 1'b0, SDA_RAND);
      run_command(OP_WRITE, 8'h3C, 1'b0, SDA_RAND);
      run_command(OP_READ, 8'h00, 1'b1, SDA_RAND);
      run_command(OP_WAIT, 8'h00, 1'b0, SDA_HIGH);
      run_command(OP_STOP, 8'h00, 1'b0, SDA_RAND);

      // random transactions over several settings
      load_timing(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
      random_traffic(100, 4);

      load_timing(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                  8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                  8'($urandom_range(1, 8)));
      hold_go = 1'b1;   // receiver stalls long, requests keep coming
      random_traffic(100, 8);

      load_timing(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
                  8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
                  8'($urandom_range(1, 20)));
      random_traffic(50, 16);
      idle_sender();    // sender waits until every response is back
      random_traffic(50, 16);

      load_timing(8'd6, 8'd6, 8'd2, 8'd5, 8'd250);
      random_traffic(100, 200);

      // closing stretch, no idling on either side
      quiet = 1'b1;
      load_timing(8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)),
                  8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)),
                  8'($urandom_range(1, 6)));
      random_traffic(130, 8);

      idle_sender();

      $display("Checked %0d responses over %0d timing settings after reset defaults.",
               rsp_checked, settings_run);
      $display("Commands finished: %0d, ack timeouts with automatic stop: %0d, mismatches: %0d.",
               done_seen, tmo_seen, fail_count);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
